FILE: rtl/tmqs_pkg.sv
`default_nettype none
package tmqs_pkg;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         queue_id;
    logic signed [31:0] msg_type;
    logic [15:0]        msg_size;
    logic [63:0]        payload;
    logic               nowait;
  } tmqs_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_type;
    logic [15:0]        out_size;
    logic [63:0]        out_payload;
    logic [6:0]         queue_msgs;
    logic [16:0]        queue_bytes;
  } tmqs_rsp_t;

  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_RECV  = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;
  localparam logic [1:0] KIND_STAT  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_RETRY   = 3'd2;
  localparam logic [2:0] ST_REFUSED = 3'd3;
  localparam logic [2:0] ST_NOSLOT  = 3'd4;
  localparam logic [2:0] ST_NOMATCH = 3'd5;

  localparam logic [1:0] CFG_ACTIVE = 2'd0;
  localparam logic [1:0] CFG_MAXB   = 2'd1;
  localparam logic [1:0] CFG_TEXT   = 2'd2;

  localparam logic [16:0] DEFAULT_QUEUE_BYTES = 17'd65536;
  localparam logic [15:0] DEFAULT_TEXT_LIMIT  = 16'd8192;

endpackage
`default_nettype wire

FILE: rtl/typed_message_queue_set.sv
// steps: a status read, a flush and any refused or invalid item go from decode to the result;
//   a send goes through decode, the slot write and the tail link; a receive reads and checks
//   each slot of the queue in turn until one matches or the walk ends, at most NUM_SLOTS slots
// throughput: one item at a time; the next item is taken once the result has been accepted
// reset: after reset the block sweeps the slot link memory, one slot a cycle,
//   and accepts no item until the sweep ends
`default_nettype none
module typed_message_queue_set
  import tmqs_pkg::*;
#(
  parameter int NUM_QUEUES = 16,
  parameter int NUM_SLOTS  = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire tmqs_req_t in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output tmqs_rsp_t      out_data_o
);

  localparam int SW = $clog2(NUM_SLOTS + 1);
  localparam int AW = $clog2(NUM_SLOTS);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [SW-1:0] NULL_SLOT = SW'(NUM_SLOTS);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_SEND  = 4'd3;
  localparam logic [3:0] S_RRD   = 4'd4;
  localparam logic [3:0] S_RCHK  = 4'd5;
  localparam logic [3:0] S_RUNL  = 4'd6;
  localparam logic [3:0] S_FLUSH = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_SRD   = 4'd9;

  // slot memory: type, size, payload together; links apart
  logic [111:0] slot_mem [NUM_SLOTS];
  logic [SW-1:0] link_mem [NUM_SLOTS];
  logic [111:0] slot_rd_q;
  logic [SW-1:0] link_rd_q;

  logic [SW-1:0] qhead_q [NUM_QUEUES];
  logic [SW-1:0] qtail_q [NUM_QUEUES];
  logic [6:0]    qcnt_q  [NUM_QUEUES];
  logic [16:0]   qbyt_q  [NUM_QUEUES];
  logic [SW-1:0] free_head_q;

  logic [4:0]  active_q;
  logic [16:0] maxb_q;
  logic [15:0] text_q;

  logic [3:0]    state_q;
  logic [SW-1:0] sweep_q;
  tmqs_req_t     req_q;
  logic [QW-1:0] qi_q;
  logic [SW-1:0] cur_q, prev_q, walk_q;
  logic          out_valid_q;
  tmqs_rsp_t     rsp_q;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          sw_en;
  logic [AW-1:0] sw_addr;
  logic [111:0]  sw_data;
  logic          lw_en;
  logic [AW-1:0] lw_addr;
  logic [SW-1:0] lw_data;

  always_ff @(posedge clk_i) begin
    if (sw_en) begin
      slot_mem[sw_addr] <= sw_data;
    end
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (rd_en) begin
      slot_rd_q <= slot_mem[rd_addr];
      link_rd_q <= link_mem[rd_addr];
    end
  end

  logic signed [32:0] sel_x, typ_x;
  logic type_match;
  always_comb begin
    sel_x = 33'(req_q.msg_type);
    typ_x = 33'(signed'(slot_rd_q[111:80]));
    type_match = (sel_x == 33'sd0) || (typ_x == sel_x) ||
                 ((sel_x < 33'sd0) && (typ_x <= -sel_x));
  end

  logic valid_q_id;
  assign valid_q_id = ({3'd0, req_q.queue_id} < {3'd0, 8'(active_q)}) &&
                      (32'(req_q.queue_id) < 32'(NUM_QUEUES));

  tmqs_rsp_t  dec_rsp;
  logic [3:0] dec_state;
  always_comb begin
    dec_rsp = '0;
    dec_rsp.queue_msgs = qcnt_q[qi_q];
    dec_rsp.queue_bytes = qbyt_q[qi_q];
    dec_state = S_DONE;
    if (!valid_q_id) begin
      dec_rsp.status = ST_INVALID;
      dec_rsp.queue_msgs = '0;
      dec_rsp.queue_bytes = '0;
    end else begin
      unique case (req_q.kind)
        KIND_SEND: begin
          if (req_q.msg_size > text_q) dec_rsp.status = ST_INVALID;
          else if (18'(qbyt_q[qi_q]) + 18'(req_q.msg_size) > 18'(maxb_q))
            dec_rsp.status = req_q.nowait ? ST_REFUSED : ST_RETRY;
          else if (free_head_q == NULL_SLOT) dec_rsp.status = ST_NOSLOT;
          else dec_state = S_SEND;
        end
        KIND_RECV: begin
          if (qhead_q[qi_q] == NULL_SLOT)
            dec_rsp.status = req_q.nowait ? ST_REFUSED : ST_RETRY;
          else dec_state = S_RCHK;
        end
        KIND_FLUSH: dec_state = S_FLUSH;
        default: ;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    sw_en = 1'b0;
    sw_addr = free_head_q[AW-1:0];
    sw_data = {req_q.msg_type, req_q.msg_size, req_q.payload};
    lw_en = 1'b0;
    lw_addr = '0;
    lw_data = '0;
    unique case (state_q)
      S_INIT: begin
        lw_en = 1'b1;
        lw_addr = sweep_q[AW-1:0];
        lw_data = sweep_q + SW'(1);
      end
      S_DEC: begin
        rd_en = 1'b1;
        rd_addr = free_head_q[AW-1:0];
        if (req_q.kind == KIND_RECV) rd_addr = qhead_q[qi_q][AW-1:0];
      end
      S_SEND: begin
        // link of the new tail: null
        sw_en = 1'b1;
        lw_en = 1'b1;
        lw_addr = free_head_q[AW-1:0];
        lw_data = NULL_SLOT;
      end
      S_SRD: begin
        lw_en = (qtail_q[qi_q] != NULL_SLOT);
        lw_addr = qtail_q[qi_q][AW-1:0];
        lw_data = cur_q;
      end
      S_RRD: begin
        rd_en = 1'b1;
        rd_addr = cur_q[AW-1:0];
      end
      S_RUNL: begin
        lw_en = (prev_q != NULL_SLOT);
        lw_addr = prev_q[AW-1:0];
        lw_data = link_rd_q;
      end
      S_FLUSH: begin
        lw_en = (qhead_q[qi_q] != NULL_SLOT);
        lw_addr = qtail_q[qi_q][AW-1:0];
        lw_data = free_head_q;
      end
      S_DONE: begin
        lw_en = (req_q.kind == KIND_RECV) && (rsp_q.status == ST_OK);
        lw_addr = cur_q[AW-1:0];
        lw_data = free_head_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      sweep_q <= '0;
      free_head_q <= '0;
      out_valid_q <= 1'b0;
      active_q <= 5'd16;
      maxb_q <= DEFAULT_QUEUE_BYTES;
      text_q <= DEFAULT_TEXT_LIMIT;
      req_q <= '0;
      qi_q <= '0;
      cur_q <= '0;
      prev_q <= '0;
      walk_q <= '0;
      rsp_q <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        qhead_q[i] <= NULL_SLOT;
        qtail_q[i] <= NULL_SLOT;
        qcnt_q[i] <= '0;
        qbyt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ACTIVE: active_q <= cfg_data_i[4:0];
          CFG_MAXB:   maxb_q <= cfg_data_i;
          CFG_TEXT:   text_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_INIT: begin
          sweep_q <= sweep_q + SW'(1);
          if (sweep_q == SW'(NUM_SLOTS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            req_q <= in_data_i;
            qi_q <= QW'(in_data_i.queue_id);
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          rsp_q <= dec_rsp;
          cur_q <= qhead_q[qi_q];
          prev_q <= NULL_SLOT;
          walk_q <= '0;
          state_q <= dec_state;
        end
        S_SEND: begin
          // link_rd_q holds the next free slot
          cur_q <= free_head_q;
          free_head_q <= link_rd_q;
          state_q <= S_SRD;
        end
        S_SRD: begin
          if (qtail_q[qi_q] == NULL_SLOT) qhead_q[qi_q] <= cur_q;
          qtail_q[qi_q] <= cur_q;
          qcnt_q[qi_q] <= qcnt_q[qi_q] + 7'd1;
          qbyt_q[qi_q] <= qbyt_q[qi_q] + 17'(req_q.msg_size);
          rsp_q.queue_msgs <= qcnt_q[qi_q] + 7'd1;
          rsp_q.queue_bytes <= qbyt_q[qi_q] + 17'(req_q.msg_size);
          state_q <= S_IDLE;
          out_valid_q <= 1'b1;
        end
        S_RRD: state_q <= S_RCHK;
        S_RCHK: begin
          if (type_match) begin
            state_q <= S_RUNL;
          end else if (link_rd_q == NULL_SLOT ||
                       walk_q == SW'(NUM_SLOTS - 1)) begin
            rsp_q.status <= ST_NOMATCH;
            state_q <= S_IDLE;
            out_valid_q <= 1'b1;
          end else begin
            prev_q <= cur_q;
            cur_q <= link_rd_q;
            walk_q <= walk_q + SW'(1);
            state_q <= S_RRD;
          end
        end
        S_RUNL: begin
          if (prev_q == NULL_SLOT) qhead_q[qi_q] <= link_rd_q;
          if (qtail_q[qi_q] == cur_q) qtail_q[qi_q] <= prev_q;
          rsp_q.out_type <= slot_rd_q[111:80];
          rsp_q.out_size <= (slot_rd_q[79:64] < req_q.msg_size) ?
                            slot_rd_q[79:64] : req_q.msg_size;
          rsp_q.out_payload <= slot_rd_q[63:0];
          qcnt_q[qi_q] <= qcnt_q[qi_q] - 7'd1;
          qbyt_q[qi_q] <= qbyt_q[qi_q] - 17'(slot_rd_q[79:64]);
          rsp_q.queue_msgs <= qcnt_q[qi_q] - 7'd1;
          rsp_q.queue_bytes <= qbyt_q[qi_q] - 17'(slot_rd_q[79:64]);
          state_q <= S_DONE;
        end
        S_FLUSH: begin
          if (qhead_q[qi_q] != NULL_SLOT) free_head_q <= qhead_q[qi_q];
          qhead_q[qi_q] <= NULL_SLOT;
          qtail_q[qi_q] <= NULL_SLOT;
          qcnt_q[qi_q] <= '0;
          qbyt_q[qi_q] <= '0;
          rsp_q.queue_msgs <= '0;
          rsp_q.queue_bytes <= '0;
          state_q <= S_IDLE;
          out_valid_q <= 1'b1;
        end
        S_DONE: begin
          if (req_q.kind == KIND_RECV && rsp_q.status == ST_OK) free_head_q <= cur_q;
          state_q <= S_IDLE;
          out_valid_q <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sim/typed_message_queue_set_tb.sv
`timescale 1ns / 1ps
module typed_message_queue_set_tb;
  import tmqs_pkg::*;

  localparam int NQ = 16;
  localparam int NS = 64;
  localparam int NULL_SLOT = NS;
  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  tmqs_req_t   in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  tmqs_rsp_t   out_data_o;

  typed_message_queue_set dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  int unsigned      m_active, m_maxb, m_text;
  logic [31:0]      s_type [NS];
  logic [15:0]      s_size [NS];
  logic [63:0]      s_pay  [NS];
  int unsigned      s_link [NS];
  int unsigned      free_hd;
  int unsigned      q_head [NQ], q_tail [NQ], q_cnt [NQ], q_bytes [NQ];

  tmqs_rsp_t rsp_pending [$];
  int        errors = 0;
  int        idle_cycles = 0;
  int unsigned rx_cyc = 0;
  bit        hold_off = 1'b0;
  bit        done = 1'b0;

  function automatic void pool_reset();
    m_active = 16; m_maxb = 65536; m_text = 8192;
    for (int i = 0; i < NS; i++) s_link[i] = i + 1;
    free_hd = 0;
    for (int i = 0; i < NQ; i++) begin
      q_head[i] = NULL_SLOT; q_tail[i] = NULL_SLOT; q_cnt[i] = 0; q_bytes[i] = 0;
    end
  endfunction

  function automatic bit type_hit(logic signed [31:0] sel, logic signed [31:0] st);
    longint s, t;
    s = sel; t = st;
    if (s == 0 || t == s) return 1'b1;
    return s < 0 && t <= -s;
  endfunction

  function automatic tmqs_rsp_t queue_apply(tmqs_req_t r);
    tmqs_rsp_t o;
    int unsigned q, prv, cur, nxt, steps;
    o = '0;
    q = r.queue_id;
    if (q >= m_active || q >= NQ) begin
      o.status = ST_INVALID;
      return o;
    end
    o.status = ST_OK;
    case (r.kind)
      KIND_SEND: begin
        if (r.msg_size > m_text) o.status = ST_INVALID;
        else if (q_bytes[q] + r.msg_size > m_maxb) o.status = r.nowait ? ST_REFUSED : ST_RETRY;
        else if (free_hd >= NS) o.status = ST_NOSLOT;
        else begin
          cur = free_hd;
          free_hd = s_link[cur];
          s_type[cur] = r.msg_type; s_size[cur] = r.msg_size; s_pay[cur] = r.payload;
          s_link[cur] = NULL_SLOT;
          if (q_tail[q] < NS) s_link[q_tail[q]] = cur;
          else q_head[q] = cur;
          q_tail[q] = cur;
          q_cnt[q]++; q_bytes[q] += r.msg_size;
        end
      end
      KIND_RECV: begin
        if (q_head[q] >= NS) o.status = r.nowait ? ST_REFUSED : ST_RETRY;
        else begin
          prv = NULL_SLOT; cur = q_head[q]; steps = 0;
          while (cur < NS && steps < NS) begin
            if (type_hit(r.msg_type, s_type[cur])) break;
            prv = cur; cur = s_link[cur]; steps++;
          end
          if (cur >= NS || steps >= NS) o.status = ST_NOMATCH;
          else begin
            nxt = s_link[cur];
            if (prv < NS) s_link[prv] = nxt;
            else q_head[q] = nxt;
            if (q_tail[q] == cur) q_tail[q] = prv;
            o.out_type = s_type[cur];
            o.out_size = s_size[cur] < r.msg_size ? s_size[cur] : r.msg_size;
            o.out_payload = s_pay[cur];
            q_cnt[q]--; q_bytes[q] -= s_size[cur];
            s_link[cur] = free_hd; free_hd = cur;
          end
        end
      end
      KIND_FLUSH: begin
        if (q_head[q] < NS && q_tail[q] < NS) begin
          s_link[q_tail[q]] = free_hd;
          free_hd = q_head[q];
        end
        q_head[q] = NULL_SLOT; q_tail[q] = NULL_SLOT; q_cnt[q] = 0; q_bytes[q] = 0;
      end
      default: ;
    endcase
    o.queue_msgs = 7'(q_cnt[q]);
    o.queue_bytes = 17'(q_bytes[q]);
    return o;
  endfunction

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    tmqs_rsp_t exp_rsp;
    if (out_valid_o && out_ready_i) begin
      if (rsp_pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        exp_rsp = rsp_pending.pop_front();
        if (out_data_o.status !== exp_rsp.status) begin
          $error("status exp %0d got %0d", exp_rsp.status, out_data_o.status); errors++;
        end
        if (out_data_o.out_type !== exp_rsp.out_type) begin
          $error("out_type exp %0d got %0d", exp_rsp.out_type, out_data_o.out_type); errors++;
        end
        if (out_data_o.out_size !== exp_rsp.out_size) begin
          $error("out_size exp %0d got %0d", exp_rsp.out_size, out_data_o.out_size); errors++;
        end
        if (out_data_o.out_payload !== exp_rsp.out_payload) begin
          $error("out_payload exp %h got %h", exp_rsp.out_payload, out_data_o.out_payload);
          errors++;
        end
        if (out_data_o.queue_msgs !== exp_rsp.queue_msgs) begin
          $error("queue_msgs exp %0d got %0d", exp_rsp.queue_msgs, out_data_o.queue_msgs);
          errors++;
        end
        if (out_data_o.queue_bytes !== exp_rsp.queue_bytes) begin
          $error("queue_bytes exp %0d got %0d", exp_rsp.queue_bytes, out_data_o.queue_bytes);
          errors++;
        end
      end
    end
    rx_cyc <= rx_cyc + 1;
    if (!rst_ni || hold_off) out_ready_i <= 1'b0;
    else if ((rx_cyc / 97) % 3 == 0) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(3, 0) != 0);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT && !done) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(tmqs_req_t r, bit typed, tmqs_rsp_t want);
    tmqs_rsp_t p;
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    p = queue_apply(r);
    if (typed && p !== want) begin
      $error("directed row disagrees: exp %p pred %p", want, p);
      errors++;
    end
    rsp_pending.push_back(p);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (rsp_pending.size() != 0) @(posedge clk_i);
    repeat (2 * NS + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= 17'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ACTIVE: m_active = val & 32'h1f;
      CFG_MAXB:   m_maxb = val & 32'h1ffff;
      default:    m_text = val & 32'hffff;
    endcase
    @(posedge clk_i);
  endtask

  function automatic tmqs_req_t mk(logic [1:0] k, int q, logic signed [31:0] t,
                                   int sz, logic [63:0] pl, bit nw);
    tmqs_req_t r;
    r.kind = k; r.queue_id = 8'(q); r.msg_type = t; r.msg_size = 16'(sz);
    r.payload = pl; r.nowait = nw;
    return r;
  endfunction

  function automatic tmqs_req_t rand_req(int qspan);
    tmqs_req_t r;
    int sel;
    r.kind = ($urandom_range(9, 0) < 5) ? KIND_SEND :
             ($urandom_range(9, 0) < 8) ? KIND_RECV :
             ($urandom_range(1, 0) ? KIND_FLUSH : KIND_STAT);
    r.queue_id = ($urandom_range(19, 0) == 0) ? 8'($urandom_range(255, 0)) :
                 8'($urandom_range(qspan - 1, 0));
    sel = $urandom_range(5, 0);
    r.msg_type = (sel == 0) ? 32'(0) : (sel == 5) ? $signed($urandom()) :
                 (sel == 4) ? -$signed(32'($urandom_range(6, 1))) : $urandom_range(6, 1);
    r.msg_size = ($urandom_range(9, 0) == 0) ? 16'($urandom()) : 16'($urandom_range(4000, 0));
    r.payload = {$urandom(), $urandom()};
    r.nowait = 1'($urandom_range(1, 0));
    return r;
  endfunction

  typedef struct {
    tmqs_req_t req;
    bit        typed;
    tmqs_rsp_t want;
  } row_t;

  function automatic tmqs_rsp_t rs(logic [2:0] st, int m, int b);
    tmqs_rsp_t o;
    o = '0; o.status = st; o.queue_msgs = 7'(m); o.queue_bytes = 17'(b);
    return o;
  endfunction

  initial begin
    row_t rows [$];
    tmqs_req_t r;
    int burst;
    pool_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    rows.push_back('{mk(KIND_STAT, 0, 0, 0, 0, 0), 1, rs(ST_OK, 0, 0)});
    rows.push_back('{mk(KIND_RECV, 0, 0, 10, 0, 0), 1, rs(ST_RETRY, 0, 0)});
    rows.push_back('{mk(KIND_RECV, 0, 0, 10, 0, 1), 1, rs(ST_REFUSED, 0, 0)});
    rows.push_back('{mk(KIND_STAT, 16, 0, 0, 0, 0), 1, rs(ST_INVALID, 0, 0)});
    rows.push_back('{mk(KIND_SEND, 255, 0, 0, 0, 0), 1, rs(ST_INVALID, 0, 0)});
    rows.push_back('{mk(KIND_SEND, 1, 7, 8193, 0, 0), 1, rs(ST_INVALID, 0, 0)});
    rows.push_back('{mk(KIND_SEND, 1, 32'h7fffffff, 8192, '1, 0), 1, rs(ST_OK, 1, 8192)});
    rows.push_back('{mk(KIND_SEND, 1, 32'h80000000, 0, 64'h5555, 1), 1, rs(ST_OK, 2, 8192)});
    rows.push_back('{mk(KIND_SEND, 1, 3, 100, 64'haaaa, 0), 0, '0});
    rows.push_back('{mk(KIND_SEND, 1, -5, 65535, 0, 0), 1, rs(ST_INVALID, 3, 8292)});
    rows.push_back('{mk(KIND_RECV, 1, 9, 50, 0, 0), 1, rs(ST_NOMATCH, 3, 8292)});
    rows.push_back('{mk(KIND_RECV, 1, 3, 50, 0, 0), 0, '0});
    rows.push_back('{mk(KIND_RECV, 1, -2, 50, 0, 0), 0, '0});
    rows.push_back('{mk(KIND_RECV, 1, 32'h80000000, 65535, 0, 0), 0, '0});
    rows.push_back('{mk(KIND_SEND, 15, 4, 10, 64'h1, 0), 0, '0});
    rows.push_back('{mk(KIND_SEND, 15, 5, 20, 64'h2, 0), 0, '0});
    rows.push_back('{mk(KIND_RECV, 15, 0, 5, 0, 1), 0, '0});
    rows.push_back('{mk(KIND_FLUSH, 15, 0, 0, 0, 0), 1, rs(ST_OK, 0, 0)});
    rows.push_back('{mk(KIND_FLUSH, 1, 0, 0, 0, 0), 1, rs(ST_OK, 0, 0)});
    for (int i = 0; i < rows.size(); i++) send_item(rows[i].req, rows[i].typed, rows[i].want);
    drain();

    // pool exhaustion, with the receiver held off
    write_reg(CFG_TEXT, 16'hffff);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < NS + 3; i++)
        send_item(mk(KIND_SEND, i % 4, i % 5, 1000, {$urandom(), $urandom()}, i[0]), 0, '0);
    join
    send_item(mk(KIND_SEND, 5, 1, 65535, 0, 0), 0, '0);
    send_item(mk(KIND_SEND, 5, 1, 2, 0, 1), 0, '0);
    for (int i = 0; i < 6; i++) send_item(mk(KIND_FLUSH, i, 0, 0, 0, 0), 0, '0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_ACTIVE, 0); write_reg(CFG_MAXB, 0); write_reg(CFG_TEXT, 0);
        end
        1: begin
          write_reg(CFG_ACTIVE, 4); write_reg(CFG_MAXB, 5000); write_reg(CFG_TEXT, 3000);
        end
        2: begin
          write_reg(CFG_ACTIVE, 31); write_reg(CFG_MAXB, 65536); write_reg(CFG_TEXT, 65535);
        end
        default: begin
          write_reg(CFG_ACTIVE, 16); write_reg(CFG_MAXB, 131071); write_reg(CFG_TEXT, 8192);
        end
      endcase
      for (int n = 0; n < (ph == 0 ? 20 : 95); ) begin
        burst = $urandom_range(12, 1);
        for (int b = 0; b < burst; b++, n++) send_item(rand_req(ph == 1 ? 6 : 16), 0, '0);
        repeat ($urandom_range(4, 0)) @(posedge clk_i);
      end
      drain();
    end

    done = 1'b1;
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
